// File: hdl/vad_pkg.sv
// Shared types, codes and constant tables for the ADPCM voice decoder.
package vad_pkg;

  // Signal range and step table size
  localparam int SigW     = 12;
  localparam int StepW    = 6;
  localparam int CodeW    = 4;
  localparam int PcmW     = 16;
  localparam int DiffW    = 13;
  localparam int StepMax  = 48;
  localparam int SigMax   = 2047;
  localparam int SigMin   = -2048;
  localparam int Leak     = 245;

  // Input beat operations
  typedef enum logic [1:0] {
    OP_CODE  = 2'd0,
    OP_RESET = 2'd1,
    OP_CLOCK = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FOUR_BIT  = 1'b0,
    CFG_DAC_TWELVE = 1'b1
  } cfg_idx_t;

  // Decoder state carried between beats
  typedef struct packed {
    logic signed [SigW-1:0] signal_level;
    logic [StepW-1:0]       step_index;
    logic [CodeW-1:0]       code_latch;
    logic                   reset_level;
  } state_t;

  // floor(16 * 1.1^step)
  function automatic logic [10:0] step_rom(input logic [StepW-1:0] idx);
    logic [10:0] v;
    case (idx)
      6'd0:  v = 11'd16;   6'd1:  v = 11'd17;   6'd2:  v = 11'd19;   6'd3:  v = 11'd21;
      6'd4:  v = 11'd23;   6'd5:  v = 11'd25;   6'd6:  v = 11'd28;   6'd7:  v = 11'd31;
      6'd8:  v = 11'd34;   6'd9:  v = 11'd37;   6'd10: v = 11'd41;   6'd11: v = 11'd45;
      6'd12: v = 11'd50;   6'd13: v = 11'd55;   6'd14: v = 11'd60;   6'd15: v = 11'd66;
      6'd16: v = 11'd73;   6'd17: v = 11'd80;   6'd18: v = 11'd88;   6'd19: v = 11'd97;
      6'd20: v = 11'd107;  6'd21: v = 11'd118;  6'd22: v = 11'd130;  6'd23: v = 11'd143;
      6'd24: v = 11'd157;  6'd25: v = 11'd173;  6'd26: v = 11'd190;  6'd27: v = 11'd209;
      6'd28: v = 11'd230;  6'd29: v = 11'd253;  6'd30: v = 11'd279;  6'd31: v = 11'd307;
      6'd32: v = 11'd337;  6'd33: v = 11'd371;  6'd34: v = 11'd408;  6'd35: v = 11'd449;
      6'd36: v = 11'd494;  6'd37: v = 11'd544;  6'd38: v = 11'd598;  6'd39: v = 11'd658;
      6'd40: v = 11'd724;  6'd41: v = 11'd796;  6'd42: v = 11'd876;  6'd43: v = 11'd963;
      6'd44: v = 11'd1060; 6'd45: v = 11'd1166; 6'd46: v = 11'd1282; 6'd47: v = 11'd1411;
      6'd48: v = 11'd1552;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

  // Step index adjustment per magnitude code
  function automatic logic signed [4:0] shift_rom(input logic [2:0] mag);
    logic signed [4:0] s;
    case (mag)
      3'd4:    s = 5'sd2;
      3'd5:    s = 5'sd4;
      3'd6:    s = 5'sd6;
      3'd7:    s = 5'sd8;
      default: s = -5'sd1;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/vad_diff.sv
// Step table lookup and signed difference from a code.
module vad_diff (
  input  logic [vad_pkg::StepW-1:0]        step_index,
  input  logic [vad_pkg::CodeW-1:0]        code,
  output logic signed [vad_pkg::DiffW-1:0] diff
);

  logic [10:0] sv;
  logic [11:0] mag;

  // Magnitude: sv/8 plus weighted sv terms for each magnitude bit
  always_comb begin
    sv  = vad_pkg::step_rom(step_index);
    mag = 12'(sv >> 3);
    if (code[2]) mag = mag + 12'(sv);
    if (code[1]) mag = mag + 12'(sv >> 1);
    if (code[0]) mag = mag + 12'(sv >> 2);
    diff = code[3] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

// File: hdl/vad_update.sv
// Next-state logic for one input beat: code latch, reset level, sample update.
module vad_update (
  input  vad_pkg::op_t    op,
  input  logic [7:0]      value,
  input  logic            four_bit_codes,
  input  vad_pkg::state_t cur,
  output vad_pkg::state_t nxt
);

  logic signed [vad_pkg::DiffW-1:0] diff;
  logic signed [21:0] sig_x;
  logic signed [21:0] diff_x;
  logic signed [21:0] sum;
  logic signed [21:0] shifted;
  logic signed [11:0] sig_new;
  logic signed [6:0]  step_sum;
  logic [5:0]         step_new;

  vad_diff u_diff (
    .step_index (cur.step_index),
    .code       (cur.code_latch),
    .diff       (diff)
  );

  // Leaky integrator: floor((sig*245 + diff*256) / 256), clamped
  always_comb begin
    sig_x   = 22'(cur.signal_level);
    diff_x  = 22'(diff);
    sum     = sig_x * 22'sd245 + (diff_x <<< 8);
    shifted = sum >>> 8;
    if (shifted > 22'sd2047)       sig_new = 12'sd2047;
    else if (shifted < -22'sd2048) sig_new = -12'sd2048;
    else                           sig_new = shifted[11:0];
  end

  // Step index adaptation, clamped to the table
  always_comb begin
    step_sum = $signed({1'b0, cur.step_index}) + 7'(vad_pkg::shift_rom(cur.code_latch[2:0]));
    if (step_sum < 7'sd0)       step_new = '0;
    else if (step_sum > 7'sd48) step_new = 6'(vad_pkg::StepMax);
    else                        step_new = step_sum[5:0];
  end

  // Operation decode
  always_comb begin
    nxt = cur;
    unique case (op)
      vad_pkg::OP_CODE: begin
        nxt.code_latch = four_bit_codes ? value[3:0] : {value[2:0], 1'b0};
      end
      vad_pkg::OP_RESET: begin
        nxt.reset_level = |value;
      end
      vad_pkg::OP_CLOCK: begin
        if (cur.reset_level) begin
          nxt.signal_level = '0;
          nxt.step_index   = '0;
        end else begin
          nxt.signal_level = sig_new;
          nxt.step_index   = step_new;
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

// File: hdl/leaky_adpcm_voice_decoder.sv
// Throughput: one beat per cycle while out_stall is low.
// Stages: input register, one update pass, result register.
// The input register holds a beat while the result register waits on out_stall.
// Reset (rst_n low, synchronous): state and latches to zero, 4-bit codes,
// 10-bit DAC, both stages empty.
module leaky_adpcm_voice_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [0:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_pcm_out,
  output logic [5:0]          out_step_level
);

  logic            four_bit_r;
  logic            dac12_r;
  logic            s1_valid_r;
  vad_pkg::op_t    s1_op_r;
  logic [7:0]      s1_value_r;
  logic            out_valid_r;
  logic signed [15:0] pcm_r;
  logic [5:0]      step_r;
  vad_pkg::state_t state_r;
  vad_pkg::state_t state_nxt;
  logic            in_take;
  logic            out_load;
  logic signed [11:0] masked;

  // Handshake: stage 1 drains when the result register is free
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r <= 1'b1;
      dac12_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (vad_pkg::cfg_idx_t'(cfg_index))
        vad_pkg::CFG_FOUR_BIT:   four_bit_r <= cfg_wdata[0];
        vad_pkg::CFG_DAC_TWELVE: dac12_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= vad_pkg::op_t'(in_operation);
      s1_value_r <= in_value;
    end
  end

  vad_update u_update (
    .op             (s1_op_r),
    .value          (s1_value_r),
    .four_bit_codes (four_bit_r),
    .cur            (state_r),
    .nxt            (state_nxt)
  );

  // Decoder state advances as each beat moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (out_load) begin
      state_r <= state_nxt;
    end
  end

  // DAC output: 10-bit mode clears the two low signal bits
  assign masked = dac12_r ? state_nxt.signal_level
                          : {state_nxt.signal_level[11:2], 2'b00};

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pcm_r  <= {masked, 4'b0000};
      step_r <= state_nxt.step_index;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pcm_out    = pcm_r;
  assign out_step_level = step_r;

endmodule

// File: test/tb_leaky_adpcm_voice_decoder.sv
// Self-checking testbench for the ADPCM voice decoder with its own sample predictor.
module tb_leaky_adpcm_voice_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code the block leaves unused
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles without any beat before the run is called hung
  localparam int QuietLimit = 2000;

  // Tracks decoder state and holds the samples the block owes us
  class adpcm_playback_tracker;
    typedef struct packed {
      logic [15:0] pcm;
      logic [5:0]  step;
    } sample_t;

    sample_t expected_samples[$];
    int      mismatches;
    bit      four_bit;
    bit      dac12;
    int      level;
    int      step_idx;
    logic [3:0] code;
    bit      held_reset;
    int      step_size[49];
    int      step_move[8];

    function new();
      four_bit   = 1'b1;
      dac12      = 1'b0;
      level      = 0;
      step_idx   = 0;
      code       = '0;
      held_reset = 1'b0;
      mismatches = 0;
      // floor(16 * 1.1^n)
      step_size = '{16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
                    73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253,
                    279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876,
                    963, 1060, 1166, 1282, 1411, 1552};
      step_move = '{-1, -1, -1, -1, 2, 4, 6, 8};
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    function void set_register(vad_pkg::cfg_idx_t idx, logic v);
      if (idx == vad_pkg::CFG_FOUR_BIT) four_bit = v;
      else if (idx == vad_pkg::CFG_DAC_TWELVE) dac12 = v;
    endfunction

    task flag(string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Apply one input beat and queue the sample it produces
    function void take_beat(logic [1:0] op, logic [7:0] val);
      int base;
      int mag;
      int lvl;
      int shown;
      sample_t s;
      case (op)
        vad_pkg::OP_CODE: code = four_bit ? val[3:0] : {val[2:0], 1'b0};
        vad_pkg::OP_RESET: held_reset = (val != 8'd0);
        vad_pkg::OP_CLOCK: begin
          if (held_reset) begin
            level    = 0;
            step_idx = 0;
          end else begin
            // sign-magnitude difference from the step size
            base = step_size[step_idx];
            mag  = base / 8;
            if (code[2]) mag += base;
            if (code[1]) mag += base / 2;
            if (code[0]) mag += base / 4;
            if (code[3]) mag = -mag;
            // leaky integrator, floor division by 256
            lvl = (level * vad_pkg::Leak + mag * 256) >>> 8;
            if (lvl > vad_pkg::SigMax) lvl = vad_pkg::SigMax;
            else if (lvl < vad_pkg::SigMin) lvl = vad_pkg::SigMin;
            level = lvl;
            step_idx += step_move[code[2:0]];
            if (step_idx > vad_pkg::StepMax) step_idx = vad_pkg::StepMax;
            else if (step_idx < 0) step_idx = 0;
          end
        end
        default: ;
      endcase
      shown = level;
      if (!dac12) shown = shown & ~3;
      s.pcm  = 16'(shown * 16);
      s.step = 6'(step_idx);
      expected_samples.push_back(s);
    endfunction

    // Compare one result beat against the oldest expected sample
    task match_sample(logic [15:0] pcm, logic [5:0] step);
      sample_t e;
      if (expected_samples.size() == 0) begin
        flag($sformatf("result beat with nothing expected (pcm %0d step %0d)",
                       $signed(pcm), step));
        return;
      end
      e = expected_samples.pop_front();
      if (pcm !== e.pcm)
        flag($sformatf("pcm_out %0d, expected %0d", $signed(pcm), $signed(e.pcm)));
      if (step !== e.step)
        flag($sformatf("step_level %0d, expected %0d", step, e.step));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = vad_pkg::CFG_FOUR_BIT;
  logic [0:0]  cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = vad_pkg::OP_CODE;
  logic [7:0]  in_value = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] out_pcm_out;
  logic [5:0]  out_step_level;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  adpcm_playback_tracker tracker = new();

  leaky_adpcm_voice_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pcm_out    (out_pcm_out),
    .out_step_level (out_step_level)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.match_sample(out_pcm_out, out_step_level);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hang detection: no beat on either side for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_leaky_adpcm_voice_decoder: FAIL");
        $finish;
      end
    end
  end

  // Drive one input beat, with random idle cycles ahead of it
  task automatic send_beat(logic [1:0] op, logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_beat(op, val);
  endtask

  // Wait for every owed sample, then let the pipeline empty
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write, then cfg_we is dropped again before the task returns
  task automatic write_register(vad_pkg::cfg_idx_t idx, logic v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(idx, v);
    @(posedge clk);
  endtask

  // One configuration and idling mode, mostly code-then-clock pairs
  task automatic random_phase(logic four, logic twelve, int snd, int rcv, int count);
    int sent;
    int r;
    logic [7:0] v;
    settle();
    write_register(vad_pkg::CFG_FOUR_BIT, four);
    write_register(vad_pkg::CFG_DAC_TWELVE, twelve);
    send_idle_pct = snd;
    stall_pct = rcv;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 84) begin
        v = 8'($urandom_range(255));
        // lean toward large magnitudes so the step index climbs and clamps
        if ($urandom_range(3) == 0) v[2] = 1'b1;
        send_beat(vad_pkg::OP_CODE, v);
        send_beat(vad_pkg::OP_CLOCK, 8'($urandom_range(255)));
        sent += 2;
      end else if (r < 88) begin
        // mostly release reset, sometimes hold it
        v = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'd0;
        send_beat(vad_pkg::OP_RESET, v);
        sent++;
      end else if (r < 94) begin
        send_beat(OpUnused, 8'($urandom_range(255)));
        sent++;
      end else if (r < 97) begin
        send_beat(vad_pkg::OP_CLOCK, 8'($urandom_range(255)));
        sent++;
      end else begin
        send_beat(vad_pkg::OP_CODE, 8'($urandom_range(255)));
        sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  int snd_pct[4] = '{0, 48, 0, 35};
  int rcv_pct[4] = '{0, 0, 48, 35};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unused op, positive clamp at top step, negative clamp, reset hold
    send_beat(OpUnused, 8'hFF);
    send_beat(vad_pkg::OP_CODE, 8'h07);
    repeat (7) send_beat(vad_pkg::OP_CLOCK, 8'h00);
    send_beat(vad_pkg::OP_CODE, 8'hFF);
    repeat (4) send_beat(vad_pkg::OP_CLOCK, 8'hFF);
    send_beat(vad_pkg::OP_CODE, 8'h08);
    send_beat(vad_pkg::OP_CLOCK, 8'h00);
    send_beat(vad_pkg::OP_RESET, 8'h01);
    send_beat(vad_pkg::OP_CLOCK, 8'h00);
    send_beat(vad_pkg::OP_CLOCK, 8'hAA);
    send_beat(vad_pkg::OP_RESET, 8'h00);
    send_beat(OpUnused, 8'h55);
    send_beat(vad_pkg::OP_CODE, 8'h04);
    send_beat(vad_pkg::OP_CLOCK, 8'h00);
    in_valid <= 1'b0;

    for (int c = 0; c < 4; c++) begin
      for (int m = 0; m < 4; m++) begin
        random_phase(c[1], c[0], snd_pct[m], rcv_pct[m], 100);
      end
    end

    settle();
    if (tracker.mismatches == 0) begin
      $display("tb_leaky_adpcm_voice_decoder: PASS");
    end else begin
      $display("tb_leaky_adpcm_voice_decoder: FAIL");
    end
    $finish;
  end

endmodule
